[rtl/core/clsw_pkg.sv]
// Package: shared types, constants and the set-address command builder.
`timescale 1ns / 1ps

package clsw_pkg;

    localparam int ROW_W = 2;

    localparam logic [7:0] SPACE_CHAR = 8'h20;
    localparam logic [7:0] SET_ADDR   = 8'h80;

    localparam logic [7:0] ROW_BASE [4] = '{8'h00, 8'h40, 8'h14, 8'h54};

    localparam logic OP_WRITE_CHAR = 1'b0;
    localparam logic OP_SET_POS    = 1'b1;

    localparam logic RS_COMMAND = 1'b0;
    localparam logic RS_DATA    = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROW_ADDR,
        ST_READ,
        ST_EMIT,
        ST_BLANK,
        ST_WRAP_ADDR
    } clsw_state_t;

    typedef struct packed {
        logic       en;
        logic       rs;
        logic [7:0] data;
        logic       last;
    } emit_t;

    // Set-address command: 0x80 | ((row base + column) & 0x7F)
    function automatic logic [7:0] set_addr_cmd(input logic [ROW_W-1:0] row,
                                                input logic [7:0] col);
        logic [7:0] sum;
        begin
            sum = ROW_BASE[row] + col;
            set_addr_cmd = SET_ADDR | {1'b0, sum[6:0]};
        end
    endfunction

endpackage

[rtl/core/char_lcd_scrolling_writer.sv]
// Top level: character-LCD text writer with cursor, line wrap and scroll store.
`timescale 1ns / 1ps

// Each accepted word becomes a run of LCD bytes (register_select 0 = command,
// 1 = data), the final one flagged by last_of_run. A character write gives
// one data byte; at the end of a row it is followed by a set-address command
// for the next row. At the end of the bottom row the screen scrolls: every
// row above the bottom is rewritten from the scroll store, the bottom row is
// blanked and the store moves up one row. Each stored character is read
// from the store in ST_READ and then sent in ST_EMIT. A set-position word
// gives one command, or nothing if it is off the screen. A new word is taken
// only in the idle state and only when the output register is empty or its
// byte leaves at the same edge, so the last byte of a run never waits there
// while the next word is accepted. The store holds COLUMNS*(ROWS-1)
// characters in a synchronous RAM; a valid flag per entry, cleared at reset,
// makes unwritten entries read as spaces, so no clearing pass is needed
// after reset.
module char_lcd_scrolling_writer
    import clsw_pkg::*;
#(
    parameter int COLUMNS = 16,
    parameter int ROWS    = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       opcode,
    input  logic [7:0] char_code,
    input  logic [4:0] target_column,
    input  logic [1:0] target_row,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       register_select,
    output logic [7:0] bus_byte,
    output logic       last_of_run
);

    localparam int COL_W   = $clog2(COLUMNS);
    localparam int ENTRIES = COLUMNS * (ROWS - 1);
    localparam int ADDR_W  = $clog2(ENTRIES);

    localparam logic [COL_W-1:0] LAST_COL      = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0] LAST_ROW      = ROW_W'(ROWS - 1);
    localparam logic [ROW_W-1:0] LAST_STORE_ROW = ROW_W'(ROWS - 2);

    clsw_state_t state_reg, state_next;

    logic [COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]  cur_row_reg, cur_row_next;
    logic [COL_W-1:0]  col_idx_reg, col_idx_next;   // column within scroll row
    logic [ROW_W-1:0]  row_idx_reg, row_idx_next;   // screen row being redrawn
    logic [ADDR_W-1:0] ptr_reg, ptr_next;           // store entry being read
    logic [ENTRIES-1:0] vld_reg, vld_next;

    logic       out_valid_reg, out_valid_next;
    logic       rs_reg, rs_next;
    logic [7:0] byte_reg, byte_next;
    logic       last_reg, last_next;

    // scroll store RAM, one write and one registered read port
    logic [7:0]        store_mem [ENTRIES];
    logic              we;
    logic [ADDR_W-1:0] wa;
    logic [7:0]        wd;
    logic              re;
    logic [7:0]        rd_data_reg;
    logic              rd_valid_reg;

    emit_t      emit;
    logic       load_ok;
    logic       in_take;
    logic       pos_ok;
    logic       at_last_col;
    logic       at_last_row;
    logic [7:0] stored_char;
    logic [ADDR_W-1:0] char_addr;

    // output slot can take a byte this cycle
    assign load_ok  = !out_valid_reg || !out_stall;
    assign in_stall = !(state_reg == ST_IDLE && load_ok);
    assign in_take  = in_valid && !in_stall;

    assign pos_ok      = (32'(target_column) < COLUMNS) && (32'(target_row) < ROWS);
    assign at_last_col = (cur_col_reg == LAST_COL);
    assign at_last_row = (cur_row_reg == LAST_ROW);
    assign stored_char = rd_valid_reg ? rd_data_reg : SPACE_CHAR;
    assign char_addr   = ADDR_W'(32'(cur_row_reg - 2'd1) * COLUMNS + 32'(cur_col_reg));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take && opcode == OP_WRITE_CHAR && at_last_col)
                begin
                    state_next = at_last_row ? ST_ROW_ADDR : ST_WRAP_ADDR;
                end
            end
            ST_ROW_ADDR:
            begin
                if (load_ok)
                begin
                    state_next = (row_idx_reg == LAST_ROW) ? ST_BLANK : ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (load_ok)
                begin
                    state_next = (col_idx_reg == LAST_COL) ? ST_ROW_ADDR : ST_READ;
                end
            end
            ST_BLANK:
            begin
                if (load_ok && col_idx_reg == LAST_COL)
                begin
                    state_next = ST_WRAP_ADDR;
                end
            end
            ST_WRAP_ADDR:
            begin
                if (load_ok)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath, store access and emitted byte
    always_comb
    begin
        emit         = '0;
        cur_col_next = cur_col_reg;
        cur_row_next = cur_row_reg;
        col_idx_next = col_idx_reg;
        row_idx_next = row_idx_reg;
        ptr_next     = ptr_reg;
        vld_next     = vld_reg;
        we           = 1'b0;
        wa           = char_addr;
        wd           = char_code;
        re           = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    if (opcode == OP_SET_POS)
                    begin
                        if (pos_ok)
                        begin
                            emit.en      = 1'b1;
                            emit.rs      = RS_COMMAND;
                            emit.data    = set_addr_cmd(target_row, 8'(target_column));
                            emit.last    = 1'b1;
                            cur_col_next = COL_W'(target_column);
                            cur_row_next = target_row;
                        end
                    end
                    else
                    begin
                        emit.en   = 1'b1;
                        emit.rs   = RS_DATA;
                        emit.data = char_code;
                        emit.last = !at_last_col;
                        // top row is never kept
                        if (cur_row_reg != '0)
                        begin
                            we           = 1'b1;
                            wa           = char_addr;
                            wd           = char_code;
                            vld_next[wa] = 1'b1;
                        end
                        if (at_last_col)
                        begin
                            cur_col_next = '0;
                            if (at_last_row)
                            begin
                                row_idx_next = '0;
                                ptr_next     = '0;
                            end
                            else
                            begin
                                cur_row_next = cur_row_reg + 2'd1;
                            end
                        end
                        else
                        begin
                            cur_col_next = cur_col_reg + 1'b1;
                        end
                    end
                end
            end
            ST_ROW_ADDR:
            begin
                if (load_ok)
                begin
                    emit.en      = 1'b1;
                    emit.rs      = RS_COMMAND;
                    emit.data    = set_addr_cmd(row_idx_reg, 8'h00);
                    col_idx_next = '0;
                end
            end
            ST_READ:
            begin
                re = 1'b1;
            end
            ST_EMIT:
            begin
                if (load_ok)
                begin
                    emit.en   = 1'b1;
                    emit.rs   = RS_DATA;
                    emit.data = stored_char;
                    // shift the entry up one store row
                    if (row_idx_reg != '0)
                    begin
                        we           = 1'b1;
                        wa           = ADDR_W'(ptr_reg - ADDR_W'(COLUMNS));
                        wd           = stored_char;
                        vld_next[wa] = 1'b1;
                    end
                    // bottom store row goes back to spaces
                    if (row_idx_reg == LAST_STORE_ROW)
                    begin
                        vld_next[ptr_reg] = 1'b0;
                    end
                    ptr_next     = ptr_reg + 1'b1;
                    col_idx_next = col_idx_reg + 1'b1;
                    if (col_idx_reg == LAST_COL)
                    begin
                        row_idx_next = row_idx_reg + 2'd1;
                    end
                end
            end
            ST_BLANK:
            begin
                if (load_ok)
                begin
                    emit.en      = 1'b1;
                    emit.rs      = RS_DATA;
                    emit.data    = SPACE_CHAR;
                    col_idx_next = col_idx_reg + 1'b1;
                end
            end
            ST_WRAP_ADDR:
            begin
                if (load_ok)
                begin
                    emit.en   = 1'b1;
                    emit.rs   = RS_COMMAND;
                    emit.data = set_addr_cmd(cur_row_reg, 8'h00);
                    emit.last = 1'b1;
                end
            end
            default:
            begin
                emit = '0;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        rs_next        = rs_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        if (emit.en)
        begin
            out_valid_next = 1'b1;
            rs_next        = emit.rs;
            byte_next      = emit.data;
            last_next      = emit.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
            col_idx_reg   <= '0;
            row_idx_reg   <= '0;
            ptr_reg       <= '0;
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_col_reg   <= cur_col_next;
            cur_row_reg   <= cur_row_next;
            col_idx_reg   <= col_idx_next;
            row_idx_reg   <= row_idx_next;
            ptr_reg       <= ptr_next;
            vld_reg       <= vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rs_reg   <= rs_next;
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_mem[wa] <= wd;
        end
        if (re)
        begin
            rd_data_reg  <= store_mem[ptr_reg];
            rd_valid_reg <= vld_reg[ptr_reg];
        end
    end

    assign out_valid       = out_valid_reg;
    assign register_select = rs_reg;
    assign bus_byte        = byte_reg;
    assign last_of_run     = last_reg;

    // cursor never leaves the screen
    a_cursor_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(cur_col_reg) < COLUMNS) && (32'(cur_row_reg) < ROWS))
        else $error("cursor off screen");

    // a flagged last byte always ends the run
    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        emit.en && emit.last |=> state_reg == ST_IDLE)
        else $error("run continues after last byte");

    // cursor sits on the bottom row for the whole redraw
    a_scroll_bottom_row: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROW_ADDR || state_reg == ST_READ || state_reg == ST_EMIT
         || state_reg == ST_BLANK) |-> cur_row_reg == LAST_ROW)
        else $error("cursor moved during scroll");

    // store reads stay within the store
    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_READ |-> (32'(ptr_reg) < ENTRIES) && (row_idx_reg != LAST_ROW))
        else $error("store read out of range");

    // a store read is always followed by its data byte
    a_read_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_READ |=> state_reg == ST_EMIT)
        else $error("read without emit");

endmodule
